// ----- rtl/escfr_pkg.sv -----
package escfr_pkg;

  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned LEN_W               = 12;
  localparam int unsigned DEF_MAX_FRAME_BYTES = 4096;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;
  localparam logic [BYTE_W-1:0] STX_BYTE = 8'h80;
  localparam logic [BYTE_W-1:0] ETX_BYTE = 8'h81;
  localparam logic [BYTE_W-1:0] STX_CODE = 8'hE7;
  localparam logic [BYTE_W-1:0] ETX_CODE = 8'hE8;
  localparam logic [BYTE_W-1:0] ESC_CODE = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic              restarted;
  } result_t;

endpackage

// ----- rtl/escaped_frame_receiver.sv -----
// Byte-stuffed frame receiver.
// Recovered bytes are registered in the result register, or in the skid
// register while a result waits. Throughput: one byte per cycle; the two-entry
// output stage keeps input accepting while one result waits, stalls it when full.
// Reset: synchronous, active high; clears frame, escape and count state and
// empties the output stage.
module escaped_frame_receiver
  import escfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              is_first,
  output logic              is_last,
  output logic [LEN_W-1:0]  frame_len,
  output logic              restarted
);

  function automatic logic [LEN_W-1:0] LEN_CAP_W(input int unsigned v);
    return v[LEN_W-1:0];
  endfunction

  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned CAP_INT =
    ((MAX_FRAME_BYTES - 1) > LEN_MAX) ? LEN_MAX : (MAX_FRAME_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_W(CAP_INT);
  localparam logic [LEN_W-1:0] LEN_ONE = {{(LEN_W-1){1'b0}}, 1'b1};

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v >= LEN_CAP) ? LEN_CAP : v + LEN_ONE;
  endfunction

  logic             in_frame, in_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [LEN_W-1:0] recovered_count, recovered_count_next;

  result_t          res;
  logic             res_valid;
  result_t          out_reg;
  result_t          skid;
  logic             skid_valid;

  logic accept;
  logic pop;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_comb begin
    in_frame_next        = in_frame;
    escape_pending_next  = escape_pending;
    recovered_count_next = recovered_count;
    res_valid            = 1'b0;
    res.data             = rx_byte;
    res.first            = 1'b0;
    res.last             = 1'b0;
    res.len              = '0;
    res.restarted        = 1'b0;
    if (!in_frame) begin
      if (rx_byte == STX_BYTE) begin
        in_frame_next        = 1'b1;
        escape_pending_next  = 1'b0;
        recovered_count_next = sat_inc('0);
        res_valid            = 1'b1;
        res.first            = 1'b1;
      end
    end else if (rx_byte == STX_BYTE) begin
      escape_pending_next  = 1'b0;
      recovered_count_next = sat_inc('0);
      res_valid            = 1'b1;
      res.first            = 1'b1;
      res.restarted        = 1'b1;
    end else if (rx_byte == ETX_BYTE) begin
      in_frame_next        = 1'b0;
      escape_pending_next  = 1'b0;
      recovered_count_next = '0;
      res_valid            = 1'b1;
      res.last             = 1'b1;
      res.len              = sat_inc(recovered_count);
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      case (rx_byte)
        STX_CODE: begin
          res_valid = 1'b1;
          res.data  = STX_BYTE;
        end
        ETX_CODE: begin
          res_valid = 1'b1;
          res.data  = ETX_BYTE;
        end
        ESC_CODE: begin
          res_valid = 1'b1;
          res.data  = ESC_BYTE;
        end
        default: res_valid = 1'b0;
      endcase
      if (res_valid) begin
        recovered_count_next = sat_inc(recovered_count);
      end
    end else if (rx_byte == ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      recovered_count_next = sat_inc(recovered_count);
      res_valid            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      escape_pending  <= 1'b0;
      recovered_count <= '0;
    end else if (accept) begin
      in_frame        <= in_frame_next;
      escape_pending  <= escape_pending_next;
      recovered_count <= recovered_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || pop) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign out_byte  = out_reg.data;
  assign is_first  = out_reg.first;
  assign is_last   = out_reg.last;
  assign frame_len = out_reg.len;
  assign restarted = out_reg.restarted;

endmodule
